@@ hdl/slip_pkg.sv @@
// ----------------------------------------------------------------------------
// slip_pkg
// shared constants and types of the slip byte codec
// ----------------------------------------------------------------------------
`default_nettype none

package slip_pkg;

    // slip special characters
    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    // operation carried in the input tuser
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // result kinds carried in the output tuser
    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    localparam int MAX_RUN   = 4;
    localparam int RUN_IDX_W = $clog2(MAX_RUN);
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    // all beats that one input beat expands into
    typedef struct packed {
        logic [RUN_CNT_W-1:0]     count;
        logic [1:0]               kind;
        logic [MAX_RUN-1:0][7:0]  bytes;
    } run_t;

endpackage

`default_nettype wire

@@ hdl/slip_byte_codec_core.sv @@
// ----------------------------------------------------------------------------
// slip_byte_codec_core
// byte-wide slip encoder and decoder sharing one stream
// ----------------------------------------------------------------------------
//  channel  | dir | tdata          | tuser          | tlast
//  s_axis   | in  | [7:0] data     | [0] op         | msg_last
//  m_axis   | out | [7:0] out_byte | [1:0] out_kind | run_last
//
//  an input beat waits in the input register until its run can move, then expands into a
//  run of zero to four result beats held in the result register
//  the result register sends one beat per cycle while m_axis_tready is high:
//  one beat for a plain encoded or decoded byte, up to four for an encoded byte
//  that opens and closes a message and needs an escape
//  a decoded esc and a decoded end that opens a frame give no beat
//  a new input beat is taken in the cycle the last beat of the run leaves
//  reset clears the codec state (no message open, no frame open, no escape)
// ----------------------------------------------------------------------------
`default_nettype none

module slip_byte_codec_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data
    input  wire logic        s_axis_tuser,   // op
    input  wire logic        s_axis_tlast,   // msg_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte
    output logic [1:0]       m_axis_tuser,   // out_kind
    output logic             m_axis_tlast    // run_last
);
    import slip_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    logic       run_free;
    logic       move;
    run_t       run;

    // the item leaves the input register once the result register can take its run
    assign move          = in_valid_reg && run_free;
    assign s_axis_tready = !in_valid_reg || move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // codec state updates when the item moves on, keeping runs in order
    slip_expand u_expand (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (move),
        .op       (in_op_reg),
        .data     (in_data_reg),
        .msg_last (in_last_reg),
        .run      (run)
    );

    // empty runs are dropped here
    slip_run_buf u_run_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (move && (run.count != '0)),
        .run           (run),
        .free          (run_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // a frame end beat carries zero and closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FRAME) |-> (m_axis_tdata == '0 && m_axis_tlast))
        else $error("frame end beat malformed");

    // decoded data is always a single-beat run
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DATA) |-> m_axis_tlast)
        else $error("decoded data run longer than one beat");

    // a decoded esc never reaches the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (move && in_op_reg == OP_DECODE && (in_data_reg == SLIP_ESC))
            |-> (run.count == '0))
        else $error("escape byte produced a result");

    // an encoded item always produces at least one line beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (move && in_op_reg == OP_ENCODE) |=> m_axis_tvalid)
        else $error("encoded item produced no beat");

endmodule

`default_nettype wire

@@ hdl/slip_expand.sv @@
// ----------------------------------------------------------------------------
// slip_expand
// codec state and expansion of one input beat into its run of result beats
// ----------------------------------------------------------------------------
`default_nettype none

module slip_expand (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic          op,
    input  wire logic [7:0]    data,
    input  wire logic          msg_last,
    output slip_pkg::run_t     run
);
    import slip_pkg::*;

    logic enc_open_reg, enc_open_next;
    logic dec_opened_reg, dec_opened_next;
    logic dec_esc_reg, dec_esc_next;

    always_comb
    begin
        logic [RUN_CNT_W-1:0] n;
        n               = '0;
        run             = '0;
        enc_open_next   = enc_open_reg;
        dec_opened_next = dec_opened_reg;
        dec_esc_next    = dec_esc_reg;

        if (op == OP_ENCODE)
        begin
            run.kind = KIND_LINE;
            if (!enc_open_reg)
            begin
                run.bytes[n[RUN_IDX_W-1:0]] = SLIP_END;
                n = n + RUN_CNT_W'(1);
            end
            if (data == SLIP_END || data == SLIP_ESC)
            begin
                run.bytes[n[RUN_IDX_W-1:0]] = SLIP_ESC;
                n = n + RUN_CNT_W'(1);
                run.bytes[n[RUN_IDX_W-1:0]] = (data == SLIP_END) ? SLIP_ESC_END
                                                                  : SLIP_ESC_ESC;
                n = n + RUN_CNT_W'(1);
            end
            else
            begin
                run.bytes[n[RUN_IDX_W-1:0]] = data;
                n = n + RUN_CNT_W'(1);
            end
            if (msg_last)
            begin
                run.bytes[n[RUN_IDX_W-1:0]] = SLIP_END;
                n = n + RUN_CNT_W'(1);
            end
            enc_open_next = !msg_last;
        end
        else
        begin
            run.kind     = KIND_DATA;
            dec_esc_next = (data == SLIP_ESC);
            case (data)
                SLIP_END:
                begin
                    // second end closes the frame, even an empty one
                    if (dec_opened_reg)
                    begin
                        run.kind = KIND_FRAME;
                        n        = RUN_CNT_W'(1);
                    end
                    dec_opened_next = !dec_opened_reg;
                end
                SLIP_ESC:
                begin
                    n = '0;
                end
                SLIP_ESC_END:
                begin
                    run.bytes[0] = dec_esc_reg ? SLIP_END : SLIP_ESC_END;
                    n            = RUN_CNT_W'(1);
                end
                SLIP_ESC_ESC:
                begin
                    run.bytes[0] = dec_esc_reg ? SLIP_ESC : SLIP_ESC_ESC;
                    n            = RUN_CNT_W'(1);
                end
                default:
                begin
                    run.bytes[0] = data;
                    n            = RUN_CNT_W'(1);
                end
            endcase
        end
        run.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_open_reg   <= 1'b0;
            dec_opened_reg <= 1'b0;
            dec_esc_reg    <= 1'b0;
        end
        else if (take)
        begin
            enc_open_reg   <= enc_open_next;
            dec_opened_reg <= dec_opened_next;
            dec_esc_reg    <= dec_esc_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/slip_run_buf.sv @@
// ----------------------------------------------------------------------------
// slip_run_buf
// result register that sends a stored run one beat per cycle while m_axis_tready is high
// ----------------------------------------------------------------------------
`default_nettype none

module slip_run_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire slip_pkg::run_t run,
    output logic               free,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // out_byte
    output logic [1:0]         m_axis_tuser,   // out_kind
    output logic               m_axis_tlast    // run_last
);
    import slip_pkg::*;

    run_t                 run_reg;
    logic                 valid_reg, valid_next;
    logic [RUN_IDX_W-1:0] idx_reg, idx_next;
    logic                 last_beat;

    assign last_beat = ({1'b0, idx_reg} + RUN_CNT_W'(1)) == run_reg.count;
    assign free      = !valid_reg || (m_axis_tready && last_beat);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (valid_reg && m_axis_tready)
        begin
            valid_next = !last_beat;
            idx_next   = idx_reg + RUN_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = run_reg.bytes[idx_reg];
    assign m_axis_tuser  = run_reg.kind;
    assign m_axis_tlast  = last_beat;

endmodule

`default_nettype wire
